>>> hw/rtl/cts_pkg.sv
// Countdown task scheduler: shared codes, command and status types.
// Used by cts_ctrl, cts_datapath and countdown_task_scheduler_core.
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

    // Slot index carried in commands (wide enough for the largest table)
    localparam int IDX_BITS = 6;

    // Operation codes of the input transaction
    localparam logic [2:0] MODE_TICK      = 3'd0;
    localparam logic [2:0] MODE_CREATE    = 3'd1;
    localparam logic [2:0] MODE_WAIT_SEM  = 3'd2;
    localparam logic [2:0] MODE_WAIT_TMR  = 3'd3;
    localparam logic [2:0] MODE_TMR_INIT  = 3'd4;
    localparam logic [2:0] MODE_SIGNAL    = 3'd5;
    localparam logic [2:0] MODE_STOP      = 3'd6;
    localparam logic [2:0] MODE_QUERY     = 3'd7;

    // Result kinds
    localparam logic [2:0] KIND_DISPATCH  = 3'd0;
    localparam logic [2:0] KIND_PASS_DONE = 3'd1;
    localparam logic [2:0] KIND_ACK       = 3'd2;
    localparam logic [2:0] KIND_CREATED   = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;
    localparam logic [2:0] KIND_QUERY     = 3'd5;

    // Task states
    localparam logic [2:0] TS_IDLE = 3'd0;
    localparam logic [2:0] TS_RUN  = 3'd1;
    localparam logic [2:0] TS_WSEM = 3'd2;
    localparam logic [2:0] TS_WTMR = 3'd3;
    localparam logic [2:0] TS_STOP = 3'd4;

    // Release causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_EVENT   = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_TICK,
        OP_DIV,
        OP_PASS,
        OP_CREATE,
        OP_FULL,
        OP_SIMPLE,
        OP_QTASK,
        OP_QTMR
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [IDX_BITS-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;       // latched operation code
        logic       slot_free;  // create: addressed slot is unallocated
        logic       div_start;  // tick: timer catch-up needs the divider
        logic       div_last;   // divider on its final step
    } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/cts_ctrl.sv
// Controller FSM: sequences slot scans, divider steps and result emission.
// Depends on cts_pkg; drives cts_datapath through cmd_t / status_t.
`timescale 1ns / 1ps
`default_nettype none
module cts_ctrl #(
    parameter int TASK_SLOTS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    output cts_pkg::cmd_t       cmd,
    input  wire cts_pkg::status_t status
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TICK, S_DIV, S_PASS,
        S_CREATE, S_FULL, S_SIMPLE, S_QTASK, S_QTMR
    } state_t;

    localparam logic [cts_pkg::IDX_BITS-1:0] LAST_SLOT =
        cts_pkg::IDX_BITS'(TASK_SLOTS - 1);

    state_t                        state_reg;
    logic [cts_pkg::IDX_BITS-1:0]  idx_reg;

    assign busy = (state_reg != S_IDLE);

    // Command decode
    always_comb
    begin
        cmd.idx = idx_reg;
        unique case (state_reg)
            S_IDLE:   cmd.op = start ? cts_pkg::OP_LOAD : cts_pkg::OP_NONE;
            S_DECODE: cmd.op = cts_pkg::OP_NONE;
            S_TICK:   cmd.op = cts_pkg::OP_TICK;
            S_DIV:    cmd.op = cts_pkg::OP_DIV;
            S_PASS:   cmd.op = cts_pkg::OP_PASS;
            S_CREATE: cmd.op = cts_pkg::OP_CREATE;
            S_FULL:   cmd.op = cts_pkg::OP_FULL;
            S_SIMPLE: cmd.op = cts_pkg::OP_SIMPLE;
            S_QTASK:  cmd.op = cts_pkg::OP_QTASK;
            S_QTMR:   cmd.op = cts_pkg::OP_QTMR;
            default:  cmd.op = cts_pkg::OP_NONE;
        endcase
    end

    // State register and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    case (status.mode)
                        cts_pkg::MODE_TICK:   state_reg <= S_TICK;
                        cts_pkg::MODE_CREATE: state_reg <= S_CREATE;
                        cts_pkg::MODE_QUERY:  state_reg <= S_QTASK;
                        default:              state_reg <= S_SIMPLE;
                    endcase
                end
                S_TICK:
                begin
                    if (status.div_start)
                        state_reg <= S_DIV;
                    else if (idx_reg == LAST_SLOT)
                        state_reg <= S_PASS;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV:
                begin
                    if (status.div_last)
                    begin
                        if (idx_reg == LAST_SLOT)
                            state_reg <= S_PASS;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TICK;
                        end
                    end
                end
                S_CREATE:
                begin
                    if (status.slot_free)
                        state_reg <= S_IDLE;
                    else if (idx_reg == LAST_SLOT)
                        state_reg <= S_FULL;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_QTASK:  state_reg <= S_QTMR;
                S_PASS, S_FULL, S_SIMPLE, S_QTMR:
                    state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // Divider is entered only from a slot visit
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ($past(state_reg) == S_TICK || $past(state_reg) == S_DIV))
        else $error("divider entered outside a tick pass");

    // Transaction start only from idle with start raised
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    // Closing results return to idle
    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS || state_reg == S_FULL) |=> (state_reg == S_IDLE))
        else $error("closing result did not end the transaction");

endmodule
`default_nettype wire

>>> hw/rtl/cts_datapath.sv
// Datapath: task, semaphore and timer tables, bit-serial remainder unit,
// and the registered result port. Depends on cts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cts_datapath #(
    parameter int TASK_SLOTS  = 16,
    parameter int SEM_SLOTS   = 16,
    parameter int TIMER_SLOTS = 16,
    parameter int PRIO_BITS   = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cts_pkg::cmd_t    cmd,
    output cts_pkg::status_t      status,
    input  wire logic [2:0]       mode,
    input  wire logic [31:0]      now_us,
    input  wire logic [3:0]       task_id,
    input  wire logic [7:0]       priority_req,
    input  wire logic [3:0]       object_id,
    input  wire logic [31:0]      time_value,
    input  wire logic             cfg_we,
    input  wire logic [7:0]       cfg_wdata,
    output logic                  result_valid,
    output logic [2:0]            kind,
    output logic [3:0]            task_id_res,
    output logic [1:0]            unblock_reason,
    output logic [2:0]            task_state,
    output logic [31:0]           value,
    output logic                  last
);

    localparam int TW = (TASK_SLOTS  > 1) ? $clog2(TASK_SLOTS)  : 1;
    localparam int SW = (SEM_SLOTS   > 1) ? $clog2(SEM_SLOTS)   : 1;
    localparam int MW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    // Task table
    logic                 used_reg      [TASK_SLOTS];
    logic [2:0]           tmode_reg     [TASK_SLOTS];
    logic [PRIO_BITS-1:0] reload_reg    [TASK_SLOTS];
    logic [PRIO_BITS-1:0] countdown_reg [TASK_SLOTS];
    logic [3:0]           target_reg    [TASK_SLOTS];
    logic [31:0]          begin_reg     [TASK_SLOTS];
    logic [31:0]          limit_reg     [TASK_SLOTS];
    logic [1:0]           cause_reg     [TASK_SLOTS];
    // Semaphores and timers
    logic                 sem_reg       [SEM_SLOTS];
    logic [31:0]          sched_reg     [TIMER_SLOTS];
    logic [31:0]          actual_reg    [TIMER_SLOTS];
    logic [31:0]          gap_reg       [TIMER_SLOTS];
    logic [31:0]          period_reg    [TIMER_SLOTS];

    // Latched transaction
    logic [2:0]           mode_reg;
    logic [31:0]          now_reg;
    logic [3:0]           tid_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [3:0]           obj_reg;
    logic [31:0]          tval_reg;

    // Remainder unit
    logic [31:0]          div_num_reg;
    logic [31:0]          div_rem_reg;
    logic [31:0]          div_den_reg;
    logic [MW-1:0]        div_tmr_reg;
    logic [4:0]           div_cnt_reg;
    logic [32:0]          div_trial;
    logic [31:0]          div_rem_next;

    // Slot access
    logic [TW-1:0]        a;
    logic                 scan_op;
    logic                 tid_ok, have, used_a;
    logic [PRIO_BITS-1:0] cd, cd1, reload_a;
    logic [2:0]           tm_a;
    logic [SW-1:0]        sem_i, os;
    logic [MW-1:0]        tm_i, om;
    logic                 sem_ok, tmr_ok, obj_sem_ok, obj_tmr_ok;
    logic [31:0]          d, p;
    logic                 timeout, evt, fires, go;
    logic [1:0]           cause_new;

    // Emission
    logic                 e_valid, e_last;
    logic [2:0]           e_kind, e_state;
    logic [3:0]           e_id;
    logic [1:0]           e_why;
    logic [31:0]          e_val;

    // Address and table reads
    always_comb
    begin
        scan_op    = (cmd.op == cts_pkg::OP_TICK) || (cmd.op == cts_pkg::OP_CREATE);
        a          = scan_op ? TW'(cmd.idx) : TW'(tid_reg);
        tid_ok     = (32'(tid_reg) < TASK_SLOTS);
        used_a     = used_reg[a];
        have       = tid_ok && used_a;
        cd         = countdown_reg[a];
        cd1        = (cd != '0) ? cd - 1'b1 : cd;
        reload_a   = reload_reg[a];
        tm_a       = tmode_reg[a];
        sem_i      = SW'(target_reg[a]);
        tm_i       = MW'(target_reg[a]);
        sem_ok     = (32'(target_reg[a]) < SEM_SLOTS);
        tmr_ok     = (32'(target_reg[a]) < TIMER_SLOTS);
        os         = SW'(obj_reg);
        om         = MW'(obj_reg);
        obj_sem_ok = (32'(obj_reg) < SEM_SLOTS);
        obj_tmr_ok = (32'(obj_reg) < TIMER_SLOTS);
        d          = now_reg - sched_reg[tm_i];
        p          = period_reg[tm_i];
        timeout    = (now_reg - begin_reg[a]) >= limit_reg[a];
        evt        = sem_ok && sem_reg[sem_i];
        fires      = tmr_ok && (d >= p);
    end

    // Release decision for the visited slot
    always_comb
    begin
        go        = 1'b0;
        cause_new = cause_reg[a];
        case (tm_a)
            cts_pkg::TS_RUN: go = 1'b1;
            cts_pkg::TS_WSEM:
            begin
                if (timeout)
                begin
                    go        = 1'b1;
                    cause_new = cts_pkg::CAUSE_TIMEOUT;
                end
                else if (evt)
                begin
                    go        = 1'b1;
                    cause_new = cts_pkg::CAUSE_EVENT;
                end
            end
            cts_pkg::TS_WTMR:
            begin
                if (fires)
                begin
                    go        = 1'b1;
                    cause_new = cts_pkg::CAUSE_EVENT;
                end
            end
            default: go = 1'b0;
        endcase
    end

    // One restoring remainder step
    always_comb
    begin
        div_trial    = {div_rem_reg, div_num_reg[31]};
        div_rem_next = (div_trial >= {1'b0, div_den_reg}) ?
                       32'(div_trial - {1'b0, div_den_reg}) : div_trial[31:0];
    end

    // Status to the controller
    always_comb
    begin
        status.mode      = mode_reg;
        status.slot_free = (cmd.op == cts_pkg::OP_CREATE) && !used_a;
        status.div_start = (cmd.op == cts_pkg::OP_TICK) && used_a &&
                           (tm_a == cts_pkg::TS_WTMR) && fires && (p != 32'd0);
        status.div_last  = (cmd.op == cts_pkg::OP_DIV) && (div_cnt_reg == 5'd31);
    end

    // Result selection
    always_comb
    begin
        e_valid = 1'b0;
        e_kind  = cts_pkg::KIND_ACK;
        e_id    = 4'd0;
        e_why   = cts_pkg::CAUSE_NONE;
        e_state = cts_pkg::TS_IDLE;
        e_val   = 32'd0;
        e_last  = 1'b0;
        case (cmd.op)
            cts_pkg::OP_TICK:
            begin
                if (used_a && go && cd1 == '0)
                begin
                    e_valid = 1'b1;
                    e_kind  = cts_pkg::KIND_DISPATCH;
                    e_id    = 4'(cmd.idx);
                    e_why   = cause_new;
                    e_state = cts_pkg::TS_RUN;
                    e_val   = 32'(reload_a);
                end
            end
            cts_pkg::OP_PASS:
            begin
                e_valid = 1'b1;
                e_kind  = cts_pkg::KIND_PASS_DONE;
                e_last  = 1'b1;
            end
            cts_pkg::OP_CREATE:
            begin
                if (!used_a)
                begin
                    e_valid = 1'b1;
                    e_kind  = cts_pkg::KIND_CREATED;
                    e_id    = 4'(cmd.idx);
                    e_state = cts_pkg::TS_RUN;
                    e_val   = 32'(prio_reg);
                    e_last  = 1'b1;
                end
            end
            cts_pkg::OP_FULL:
            begin
                e_valid = 1'b1;
                e_kind  = cts_pkg::KIND_FULL;
                e_last  = 1'b1;
            end
            cts_pkg::OP_SIMPLE:
            begin
                e_valid = 1'b1;
                e_kind  = cts_pkg::KIND_ACK;
                e_last  = 1'b1;
            end
            cts_pkg::OP_QTASK:
            begin
                e_valid = 1'b1;
                e_kind  = cts_pkg::KIND_QUERY;
                e_id    = tid_reg;
                if (have)
                begin
                    e_why   = cause_reg[a];
                    e_state = tm_a;
                    e_val   = 32'(reload_a);
                end
            end
            cts_pkg::OP_QTMR:
            begin
                e_valid = 1'b1;
                e_kind  = cts_pkg::KIND_QUERY;
                e_val   = obj_tmr_ok ? gap_reg[om] : 32'd0;
                e_last  = 1'b1;
            end
            default: e_valid = 1'b0;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= e_valid;
    end

    always_ff @(posedge clk)
    begin
        if (e_valid)
        begin
            kind           <= e_kind;
            task_id_res    <= e_id;
            unblock_reason <= e_why;
            task_state     <= e_state;
            value          <= e_val;
            last           <= e_last;
        end
    end

    // Input latch and remainder unit
    always_ff @(posedge clk)
    begin
        if (cmd.op == cts_pkg::OP_LOAD)
        begin
            mode_reg <= mode;
            now_reg  <= now_us;
            tid_reg  <= task_id;
            prio_reg <= PRIO_BITS'(priority_req);
            obj_reg  <= object_id;
            tval_reg <= time_value;
        end
        if (status.div_start)
        begin
            div_num_reg <= d;
            div_rem_reg <= 32'd0;
            div_den_reg <= p;
            div_tmr_reg <= tm_i;
            div_cnt_reg <= 5'd0;
        end
        else if (cmd.op == cts_pkg::OP_DIV)
        begin
            div_num_reg <= {div_num_reg[30:0], 1'b0};
            div_rem_reg <= div_rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Tables without reset value
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            cts_pkg::OP_TICK:
            begin
                if (used_a && tm_a == cts_pkg::TS_WTMR && fires)
                begin
                    actual_reg[tm_i] <= now_reg;
                    if (p == 32'd0)
                        sched_reg[tm_i] <= now_reg;
                end
            end
            // sched = now - (elapsed mod period)
            cts_pkg::OP_DIV:
            begin
                if (div_cnt_reg == 5'd31)
                    sched_reg[div_tmr_reg] <= now_reg - div_rem_next;
            end
            cts_pkg::OP_CREATE:
            begin
                if (!used_a)
                begin
                    begin_reg[a] <= 32'd0;
                    limit_reg[a] <= 32'd0;
                end
            end
            cts_pkg::OP_SIMPLE:
            begin
                if (mode_reg == cts_pkg::MODE_WAIT_SEM && have && obj_sem_ok)
                begin
                    begin_reg[a] <= now_reg;
                    limit_reg[a] <= tval_reg;
                end
                if (mode_reg == cts_pkg::MODE_TMR_INIT && obj_tmr_ok)
                begin
                    sched_reg[om]  <= now_reg;
                    actual_reg[om] <= now_reg;
                    period_reg[om] <= tval_reg;
                end
            end
            default: ;
        endcase
    end

    // Tables with reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                used_reg[i]      <= (i == 0);
                tmode_reg[i]     <= (i == 0) ? cts_pkg::TS_RUN : cts_pkg::TS_IDLE;
                reload_reg[i]    <= '0;
                countdown_reg[i] <= '0;
                target_reg[i]    <= 4'd0;
                cause_reg[i]     <= cts_pkg::CAUSE_NONE;
            end
            for (int i = 0; i < SEM_SLOTS; i++)
                sem_reg[i] <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
                gap_reg[i] <= 32'd0;
        end
        else
        begin
            case (cmd.op)
                cts_pkg::OP_TICK:
                begin
                    if (used_a)
                    begin
                        countdown_reg[a] <= cd1;
                        cause_reg[a]     <= cause_new;
                        if (go)
                        begin
                            tmode_reg[a] <= cts_pkg::TS_RUN;
                            if (cd1 == '0)
                                countdown_reg[a] <= reload_a;
                        end
                        if (tm_a == cts_pkg::TS_WSEM && !timeout && evt)
                            sem_reg[sem_i] <= 1'b0;
                        if (tm_a == cts_pkg::TS_WTMR && fires)
                            gap_reg[tm_i] <= now_reg - actual_reg[tm_i];
                    end
                end
                cts_pkg::OP_CREATE:
                begin
                    if (!used_a)
                    begin
                        used_reg[a]      <= 1'b1;
                        tmode_reg[a]     <= cts_pkg::TS_RUN;
                        reload_reg[a]    <= prio_reg;
                        countdown_reg[a] <= prio_reg;
                        target_reg[a]    <= 4'd0;
                        cause_reg[a]     <= cts_pkg::CAUSE_NONE;
                    end
                end
                cts_pkg::OP_SIMPLE:
                begin
                    case (mode_reg)
                        cts_pkg::MODE_WAIT_SEM:
                        begin
                            if (have && obj_sem_ok)
                            begin
                                target_reg[a] <= obj_reg;
                                cause_reg[a]  <= cts_pkg::CAUSE_NONE;
                                tmode_reg[a]  <= cts_pkg::TS_WSEM;
                            end
                        end
                        cts_pkg::MODE_WAIT_TMR:
                        begin
                            if (have && obj_tmr_ok)
                            begin
                                target_reg[a] <= obj_reg;
                                cause_reg[a]  <= cts_pkg::CAUSE_NONE;
                                tmode_reg[a]  <= cts_pkg::TS_WTMR;
                            end
                        end
                        cts_pkg::MODE_TMR_INIT:
                        begin
                            if (obj_tmr_ok)
                                gap_reg[om] <= 32'd0;
                        end
                        cts_pkg::MODE_SIGNAL:
                        begin
                            if (obj_sem_ok)
                                sem_reg[os] <= 1'b1;
                        end
                        cts_pkg::MODE_STOP:
                        begin
                            if (have)
                                tmode_reg[a] <= cts_pkg::TS_STOP;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            // System task reload; user writes only in idle (unenforced)
            if (cfg_we)
            begin
                reload_reg[0]    <= PRIO_BITS'(cfg_wdata);
                countdown_reg[0] <= PRIO_BITS'(cfg_wdata);
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/countdown_task_scheduler_core.sv
// Channel    | Signals                                          | Handshake
// command    | mode now_us task_id priority_req object_id       | start, busy
//            | time_value                                       |
// result     | kind task_id_res unblock_reason task_state value | result_valid strobe
//            | last                                             |
// config     | cfg_wdata                                        | cfg_we
//
// A tick visits every task slot in turn and runs the bit-serial remainder unit
// for each timer that fires with a nonzero period. Create scans the slots
// until one is free; query emits two results, other operations one.
// Reset clears semaphores, timer gaps and all tasks but slot 0 at once.
// Results leave as one-cycle strobes; the receiver cannot stall.
// Top level; depends on cts_pkg, cts_ctrl, cts_datapath.
`timescale 1ns / 1ps
`default_nettype none
module countdown_task_scheduler_core #(
    parameter int TASK_SLOTS  = 16,
    parameter int SEM_SLOTS   = 16,
    parameter int TIMER_SLOTS = 16,
    parameter int PRIO_BITS   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] now_us,
    input  wire logic [3:0]  task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [3:0]  object_id,
    input  wire logic [31:0] time_value,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    output logic             result_valid,
    output logic [2:0]       kind,
    output logic [3:0]       task_id_res,
    output logic [1:0]       unblock_reason,
    output logic [2:0]       task_state,
    output logic [31:0]      value,
    output logic             last
);

    cts_pkg::cmd_t    cmd;
    cts_pkg::status_t status;

    cts_ctrl #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    cts_datapath #(
        .TASK_SLOTS  (TASK_SLOTS),
        .SEM_SLOTS   (SEM_SLOTS),
        .TIMER_SLOTS (TIMER_SLOTS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (mode),
        .now_us         (now_us),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .object_id      (object_id),
        .time_value     (time_value),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .result_valid   (result_valid),
        .kind           (kind),
        .task_id_res    (task_id_res),
        .unblock_reason (unblock_reason),
        .task_state     (task_state),
        .value          (value),
        .last           (last)
    );

endmodule
`default_nettype wire

>>> dv/countdown_task_scheduler_core_tb.sv
// Self-checking testbench for countdown_task_scheduler_core: directed table plus random
// scheduler traffic, every result compared against a behavioral scheduler model.
// Depends on cts_pkg and the RTL of countdown_task_scheduler_core.
`timescale 1ns / 1ps
module countdown_task_scheduler_core_tb;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  tid;
        logic [1:0]  why;
        logic [2:0]  st;
        logic [31:0] val;
        logic        lst;
    } sched_res_t;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] now;
        logic [3:0]  tid;
        logic [7:0]  prio;
        logic [3:0]  obj;
        logic [31:0] tval;
        bit          has_exp;
        sched_res_t  exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  mode = '0;
    logic [31:0] now_us = '0;
    logic [3:0]  task_id = '0;
    logic [7:0]  priority_req = '0;
    logic [3:0]  object_id = '0;
    logic [31:0] time_value = '0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        busy, result_valid, last;
    logic [2:0]  kind, task_state;
    logic [3:0]  task_id_res;
    logic [1:0]  unblock_reason;
    logic [31:0] value;

    countdown_task_scheduler_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .now_us(now_us), .task_id(task_id), .priority_req(priority_req),
        .object_id(object_id), .time_value(time_value), .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata), .result_valid(result_valid), .kind(kind),
        .task_id_res(task_id_res), .unblock_reason(unblock_reason),
        .task_state(task_state), .value(value), .last(last)
    );

    always #5 clk = ~clk;

    // Scheduler shadow state
    bit          m_used[16];
    logic [2:0]  m_state[16];
    logic [7:0]  m_reload[16];
    logic [7:0]  m_count[16];
    logic [3:0]  m_target[16];
    logic [31:0] m_wbegin[16];
    logic [31:0] m_wlimit[16];
    logic [1:0]  m_cause[16];
    bit          m_flag[16];
    logic [31:0] m_sched[16];
    logic [31:0] m_actual[16];
    logic [31:0] m_gap[16];
    logic [31:0] m_period[16];
    bit          tmr_ready[16];

    sched_res_t  pending_results[$];
    sched_res_t  first_res;
    int          mismatches = 0;
    int          results_seen = 0;
    int          dispatches = 0;
    int          quiet_cycles = 0;
    int          idle_pct = 0;
    logic [31:0] clock_us = 0;

    function automatic sched_res_t mk(logic [2:0] k, logic [3:0] t, logic [1:0] w,
                                      logic [2:0] s, logic [31:0] v, logic l);
        sched_res_t r;
        r.kind = k; r.tid = t; r.why = w; r.st = s; r.val = v; r.lst = l;
        return r;
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < 16; i++)
        begin
            m_used[i] = (i == 0);
            m_state[i] = (i == 0) ? cts_pkg::TS_RUN : cts_pkg::TS_IDLE;
            m_reload[i] = 0; m_count[i] = 0; m_target[i] = 0; m_wbegin[i] = 0;
            m_wlimit[i] = 0; m_cause[i] = cts_pkg::CAUSE_NONE; m_flag[i] = 0;
            m_sched[i] = 0; m_actual[i] = 0; m_gap[i] = 0; m_period[i] = 0;
            tmr_ready[i] = 0;
        end
    endfunction

    // Timer catch-up: fires once, advances schedule by whole periods
    function automatic bit timer_expired(logic [3:0] t, logic [31:0] now);
        logic [31:0] d;
        d = now - m_sched[t];
        if (d < m_period[t])
            return 0;
        m_gap[t] = now - m_actual[t];
        m_actual[t] = now;
        if (m_period[t] == 0)
            m_sched[t] = now;
        else
            m_sched[t] = m_sched[t] + (d / m_period[t]) * m_period[t];
        return 1;
    endfunction

    // Apply one command to the shadow state, queue the results it causes
    function automatic void schedule_cmd(logic [2:0] md, logic [31:0] now, logic [3:0] tid,
                                         logic [7:0] prio, logic [3:0] obj, logic [31:0] tv);
        bit have, go, done;
        int sz0;
        sz0 = pending_results.size();
        have = m_used[tid];
        done = 0;
        case (md)
            cts_pkg::MODE_TICK:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (m_used[i])
                    begin
                        go = 0;
                        if (m_count[i] != 0) m_count[i]--;
                        if (m_state[i] == cts_pkg::TS_RUN) go = 1;
                        else if (m_state[i] == cts_pkg::TS_WSEM)
                        begin
                            if (now - m_wbegin[i] >= m_wlimit[i])
                            begin
                                m_cause[i] = cts_pkg::CAUSE_TIMEOUT; go = 1;
                            end
                            else if (m_flag[m_target[i]])
                            begin
                                m_flag[m_target[i]] = 0;
                                m_cause[i] = cts_pkg::CAUSE_EVENT; go = 1;
                            end
                        end
                        else if (m_state[i] == cts_pkg::TS_WTMR)
                        begin
                            if (timer_expired(m_target[i], now))
                            begin
                                m_cause[i] = cts_pkg::CAUSE_EVENT; go = 1;
                            end
                        end
                        if (go)
                        begin
                            m_state[i] = cts_pkg::TS_RUN;
                            if (m_count[i] == 0)
                            begin
                                pending_results.push_back(mk(cts_pkg::KIND_DISPATCH, 4'(i),
                                                             m_cause[i], cts_pkg::TS_RUN,
                                                             32'(m_reload[i]), 0));
                                m_count[i] = m_reload[i];
                            end
                        end
                    end
                end
                pending_results.push_back(mk(cts_pkg::KIND_PASS_DONE, 0, 0, 0, 0, 1));
            end
            cts_pkg::MODE_CREATE:
            begin
                for (int i = 0; i < 16 && !done; i++)
                begin
                    if (!m_used[i])
                    begin
                        m_used[i] = 1; m_state[i] = cts_pkg::TS_RUN; m_reload[i] = prio;
                        m_count[i] = prio; m_target[i] = 0; m_wbegin[i] = 0;
                        m_wlimit[i] = 0; m_cause[i] = cts_pkg::CAUSE_NONE;
                        pending_results.push_back(mk(cts_pkg::KIND_CREATED, 4'(i), 0,
                                                     cts_pkg::TS_RUN, 32'(prio), 1));
                        done = 1;
                    end
                end
                if (!done) pending_results.push_back(mk(cts_pkg::KIND_FULL, 0, 0, 0, 0, 1));
            end
            cts_pkg::MODE_QUERY:
            begin
                if (have)
                    pending_results.push_back(mk(cts_pkg::KIND_QUERY, tid, m_cause[tid],
                                                 m_state[tid], 32'(m_reload[tid]), 0));
                else
                    pending_results.push_back(mk(cts_pkg::KIND_QUERY, tid, 0,
                                                 cts_pkg::TS_IDLE, 0, 0));
                pending_results.push_back(mk(cts_pkg::KIND_QUERY, 0, 0, 0, m_gap[obj], 1));
            end
            default:
            begin
                if (md == cts_pkg::MODE_WAIT_SEM && have)
                begin
                    m_target[tid] = obj; m_wbegin[tid] = now; m_wlimit[tid] = tv;
                    m_cause[tid] = cts_pkg::CAUSE_NONE; m_state[tid] = cts_pkg::TS_WSEM;
                end
                else if (md == cts_pkg::MODE_WAIT_TMR && have)
                begin
                    m_target[tid] = obj; m_cause[tid] = cts_pkg::CAUSE_NONE;
                    m_state[tid] = cts_pkg::TS_WTMR;
                end
                else if (md == cts_pkg::MODE_TMR_INIT)
                begin
                    m_sched[obj] = now; m_actual[obj] = now; m_gap[obj] = 0;
                    m_period[obj] = tv; tmr_ready[obj] = 1;
                end
                else if (md == cts_pkg::MODE_SIGNAL)
                    m_flag[obj] = 1;
                else if (md == cts_pkg::MODE_STOP && have)
                    m_state[tid] = cts_pkg::TS_STOP;
                pending_results.push_back(mk(cts_pkg::KIND_ACK, 0, 0, 0, 0, 1));
            end
        endcase
        first_res = pending_results[sz0];
    endfunction

    // Result checking on every strobe
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            sched_res_t got, want;
            got = mk(kind, task_id_res, unblock_reason, task_state, value, last);
            results_seen++;
            if (kind == cts_pkg::KIND_DISPATCH) dispatches++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d id=%0d val=%0h", kind, task_id_res,
                             value);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp k=%0d id=%0d why=%0d st=%0d v=%0h l=%0d",
                                  " / got k=%0d id=%0d why=%0d st=%0d v=%0h l=%0d"},
                                 want.kind, want.tid, want.why, want.st, want.val, want.lst,
                                 got.kind, got.tid, got.why, got.st, got.val, got.lst);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("countdown_task_scheduler_core_tb: errors");
            $finish;
        end
    end

    // Send one command transaction, with optional idle gap before it;
    // start stays high after acceptance until the next gap or drain
    task automatic issue(logic [2:0] md, logic [31:0] now, logic [3:0] tid, logic [7:0] prio,
                         logic [3:0] obj, logic [31:0] tv);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1; mode <= md; now_us <= now; task_id <= tid; priority_req <= prio;
        object_id <= obj; time_value <= tv;
        do @(posedge clk); while (busy);
        schedule_cmd(md, now, tid, prio, obj, tv);
    endtask

    task automatic drain_and_config(logic [7:0] sp);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_we <= 1'b1; cfg_wdata <= sp;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_reload[0] = sp; m_count[0] = sp;
    endtask

    // Pick a random operation, mostly well-formed task activity
    task automatic random_cmd();
        int r;
        logic [3:0] obj, tid;
        logic [31:0] tv;
        r = $urandom_range(99);
        tid = 4'($urandom_range(15));
        obj = 4'($urandom_range(15));
        tv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(300);
        clock_us = clock_us + $urandom_range(120);
        if ($urandom_range(30) == 0) clock_us = $urandom;
        if (r < 35)
            issue(cts_pkg::MODE_TICK, clock_us, tid, 0, obj, 0);
        else if (r < 45)
            issue(cts_pkg::MODE_CREATE, clock_us, tid,
                  8'(($urandom_range(3) == 0) ? $urandom : $urandom_range(3)), obj, 0);
        else if (r < 55)
            issue(cts_pkg::MODE_WAIT_SEM, clock_us, tid, 0, obj, tv);
        else if (r < 63)
        begin
            // never wait on a timer that was never initialized
            if (!tmr_ready[obj]) issue(cts_pkg::MODE_TMR_INIT, clock_us, tid, 0, obj, tv);
            else issue(cts_pkg::MODE_WAIT_TMR, clock_us, tid, 0, obj, tv);
        end
        else if (r < 70)
            issue(cts_pkg::MODE_TMR_INIT, clock_us, tid, 0, obj, tv);
        else if (r < 82)
            issue(cts_pkg::MODE_SIGNAL, clock_us, tid, 0, obj, 0);
        else if (r < 88)
            issue(cts_pkg::MODE_STOP, clock_us, tid, 0, obj, 0);
        else
            issue(cts_pkg::MODE_QUERY, clock_us, tid, 8'($urandom), obj, $urandom);
    endtask

    stim_row_t dir_rows[$];

    function automatic void add_row(logic [2:0] md, logic [31:0] now, logic [3:0] tid,
                                    logic [7:0] prio, logic [3:0] obj, logic [31:0] tv,
                                    bit he, sched_res_t e);
        stim_row_t s;
        s.mode = md; s.now = now; s.tid = tid; s.prio = prio; s.obj = obj; s.tval = tv;
        s.has_exp = he; s.exp = e;
        dir_rows.push_back(s);
    endfunction

    initial
    begin
        sched_res_t none;
        int phase_pct[4];
        none = '0;
        phase_pct[0] = 0; phase_pct[1] = 85; phase_pct[2] = 34; phase_pct[3] = 0;
        sched_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed expectations cross-check the shadow model
        add_row(cts_pkg::MODE_QUERY, 0, 4'd15, 8'hFF, 4'd15, '1, 1,
                mk(cts_pkg::KIND_QUERY, 15, 0, cts_pkg::TS_IDLE, 0, 0));
        add_row(cts_pkg::MODE_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 1,
                mk(cts_pkg::KIND_DISPATCH, 0, 0, cts_pkg::TS_RUN, 0, 0));
        add_row(cts_pkg::MODE_CREATE, 10, 0, 8'hFF, 0, 0, 1,
                mk(cts_pkg::KIND_CREATED, 1, 0, cts_pkg::TS_RUN, 255, 1));
        add_row(cts_pkg::MODE_CREATE, 10, 0, 8'h00, 0, 0, 1,
                mk(cts_pkg::KIND_CREATED, 2, 0, cts_pkg::TS_RUN, 0, 1));
        add_row(cts_pkg::MODE_TMR_INIT, 100, 0, 0, 4'd15, 32'd50, 1,
                mk(cts_pkg::KIND_ACK, 0, 0, 0, 0, 1));
        add_row(cts_pkg::MODE_TMR_INIT, 100, 0, 0, 4'd0, 32'd0, 0, none);
        add_row(cts_pkg::MODE_WAIT_SEM, 100, 4'd2, 0, 4'd15, 32'hFFFF_FFFF, 0, none);
        add_row(cts_pkg::MODE_SIGNAL, 110, 0, 0, 4'd15, 0, 0, none);
        add_row(cts_pkg::MODE_TICK, 120, 0, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_WAIT_SEM, 120, 4'd2, 0, 4'd3, 32'd0, 0, none);
        add_row(cts_pkg::MODE_TICK, 120, 0, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_WAIT_TMR, 130, 4'd2, 0, 4'd15, 0, 0, none);
        add_row(cts_pkg::MODE_TICK, 260, 0, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_WAIT_TMR, 270, 4'd1, 0, 4'd0, 0, 0, none);
        add_row(cts_pkg::MODE_TICK, 280, 0, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_QUERY, 280, 4'd2, 0, 4'd15, 0, 0, none);
        add_row(cts_pkg::MODE_STOP, 290, 4'd1, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_STOP, 290, 4'd9, 0, 0, 0, 0, none);
        add_row(cts_pkg::MODE_WAIT_SEM, 290, 4'd9, 0, 0, 5, 0, none);
        add_row(cts_pkg::MODE_QUERY, 300, 4'd1, 0, 4'd0, 0, 0, none);
        add_row(cts_pkg::MODE_WAIT_SEM, 300, 4'd1, 0, 4'd5, 32'd1000, 0, none);
        add_row(cts_pkg::MODE_TICK, 300, 0, 0, 0, 0, 0, none);
        for (int i = 0; i < 14; i++)
            add_row(cts_pkg::MODE_CREATE, 0, 0, 8'(i), 0, 0, 0, none);
        add_row(cts_pkg::MODE_TICK, 400, 0, 0, 0, 0, 0, none);

        foreach (dir_rows[i])
        begin
            issue(dir_rows[i].mode, dir_rows[i].now, dir_rows[i].tid, dir_rows[i].prio,
                  dir_rows[i].obj, dir_rows[i].tval);
            if (dir_rows[i].has_exp && first_res !== dir_rows[i].exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("model disagrees with table row %0d", i);
            end
        end
        clock_us = 400;

        // Random phases, system priority changed between them (extremes included)
        for (int p = 0; p < 4; p++)
        begin
            drain_and_config(p == 0 ? 8'hFF : (p == 1 ? 8'h00 :
                             (p == 2 ? 8'h01 : 8'($urandom))));
            // set the chance of an idle gap before each command in this phase
            idle_pct = phase_pct[p];
            for (int k = 0; k < 45; k++) random_cmd();
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("covered %0d results, %0d dispatches, four idle phases, priorities 0..255",
                 results_seen, dispatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("countdown_task_scheduler_core_tb: clean");
        else
            $display("countdown_task_scheduler_core_tb: errors");
        $finish;
    end
endmodule
